>>> rtl/svt_pkg.sv
// shared constants, types and codes for the sorted value table
package svt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } svt_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2
  } svt_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_WRITE_NEW
  } svt_state_e;

  // one write port and one read port per cycle
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    idx_t  raddr;
  } svt_ram_req_t;

endpackage

>>> rtl/svt_ram.sv
// entry storage: one write and one registered read per cycle
module svt_ram (
  input  logic                clk_i,
  input  svt_pkg::svt_ram_req_t req_i,
  output svt_pkg::data_t      rdata_o
);
  import svt_pkg::*;

  data_t mem [TABLE_DEPTH];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sorted_value_table.sv
// sorted value table: ascending table of signed words with insert, delete, search, clear
// clear, insert into a full table and delete or search on an empty table answer from idle;
//   search and delete scan from entry 0 and delete then moves the entries above the hit down;
//   insert scans, moves entries up and writes; append skips the move, empty table the scan
// one word at a time, busy_o high until the result strobe
// reset: the entry count clears at once, entries stay undefined and need no clearing pass
module sorted_value_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic signed [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  position_o,
  output logic [4:0]  entry_count_o,
  output logic        is_empty_o
);
  import svt_pkg::*;

  // control state
  svt_state_e  state_q, state_d;
  cnt_t        count_q, count_d;
  logic        done_q, done_d;

  // per-command working registers
  svt_cmd_e    cmd_q, cmd_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  idx_t        chk_idx_q, chk_idx_d;   // entry whose read data arrives this cycle
  idx_t        sh_idx_q, sh_idx_d;     // entry written by the shift
  idx_t        pos_q, pos_d;
  svt_status_e status_q, status_d;

  // memory port
  svt_ram_req_t ram_req;
  data_t        ram_rdata;

  // scan compare
  logic hit;
  logic last;

  svt_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // insert stops at the first entry not smaller, delete and search at the first equal one
  always_comb begin
    if (cmd_q == CMD_INSERT) begin
      hit = !($signed(ram_rdata) < value_q);
    end else begin
      hit = ($signed(ram_rdata) == value_q);
    end
    last = (cnt_t'(chk_idx_q) == (count_q - cnt_t'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    value_q   <= value_d;
    chk_idx_q <= chk_idx_d;
    sh_idx_q  <= sh_idx_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    cmd_d     = cmd_q;
    value_d   = value_q;
    chk_idx_d = chk_idx_q;
    sh_idx_d  = sh_idx_q;
    pos_d     = pos_q;
    status_d  = status_q;

    // by default read one ahead of the entry being compared
    ram_req.we    = 1'b0;
    ram_req.waddr = sh_idx_q;
    ram_req.wdata = ram_rdata;
    ram_req.raddr = chk_idx_q + idx_t'(1);

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d     = svt_cmd_e'(command_i);
          value_d   = value_i;
          chk_idx_d = '0;
          pos_d     = '0;
          status_d  = STATUS_OK;
          ram_req.raddr = '0;
          case (svt_cmd_e'(command_i))
            CMD_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            CMD_INSERT: begin
              if (count_q == cnt_t'(TABLE_DEPTH)) begin
                // full table is left untouched
                status_d = STATUS_FULL;
                done_d   = 1'b1;
              end else if (count_q == '0) begin
                state_d = ST_WRITE_NEW;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              // delete or search
              if (count_q == '0) begin
                status_d = STATUS_ABSENT;
                done_d   = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          pos_d = chk_idx_q;
          case (cmd_q)
            CMD_SEARCH: begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
            CMD_DELETE: begin
              if (last) begin
                // removing the top entry needs no move
                count_d = count_q - cnt_t'(1);
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end else begin
                // read of the next entry is already under way
                sh_idx_d = chk_idx_q;
                state_d  = ST_SHIFT_UP;
              end
            end
            CMD_INSERT: begin
              // open a gap: move entries up starting at the top
              ram_req.raddr = idx_t'(count_q - cnt_t'(1));
              sh_idx_d      = idx_t'(count_q);
              state_d       = ST_SHIFT_DN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end else if (last) begin
          if (cmd_q == CMD_INSERT) begin
            // larger than everything stored: append
            pos_d   = idx_t'(count_q);
            state_d = ST_WRITE_NEW;
          end else begin
            status_d = STATUS_ABSENT;
            pos_d    = '0;
            done_d   = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          chk_idx_d = chk_idx_q + idx_t'(1);
        end
      end

      ST_SHIFT_UP: begin
        // close the gap: entry sh+1 moves down to sh
        ram_req.we = 1'b1;
        if ((cnt_t'(sh_idx_q) + cnt_t'(2)) == count_q) begin
          count_d = count_q - cnt_t'(1);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_req.raddr = sh_idx_q + idx_t'(2);
          sh_idx_d      = sh_idx_q + idx_t'(1);
        end
      end

      ST_SHIFT_DN: begin
        // entry sh-1 moves up to sh
        ram_req.we = 1'b1;
        if ((sh_idx_q - idx_t'(1)) == pos_q) begin
          state_d = ST_WRITE_NEW;
        end else begin
          ram_req.raddr = sh_idx_q - idx_t'(2);
          sh_idx_d      = sh_idx_q - idx_t'(1);
        end
      end

      ST_WRITE_NEW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_q;
        ram_req.wdata = data_t'(value_q);
        count_d       = count_q + cnt_t'(1);
        done_d        = 1'b1;
        state_d       = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // results come straight from registers; the count register is already updated
  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign position_o    = 4'(pos_q);
  assign entry_count_o = 5'(count_q);
  assign is_empty_o    = (count_q == '0);

  // a result only shows once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // an accepted word either answers at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted word lost");

  // the count moves only with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(count_q))
    else $error("entry count changed without a result");

  // full is reported only with a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_q == STATUS_FULL)) |-> (count_q == cnt_t'(TABLE_DEPTH)))
    else $error("full status with room left");

  // the table never grows past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE_NEW) |-> (count_q < cnt_t'(TABLE_DEPTH)))
    else $error("insert into full table");

endmodule
